### design/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// Used by pva_start_mem, polyphonic_voice_allocator_top, pva_alloc_checker and the test; no dependencies.
package pva_pkg;

    // Default voice pool size.
    localparam int DEFAULT_MAX_VOICES = 16;

    // Field widths fixed by the stream format.
    localparam int KIND_W     = 2;
    localparam int VIDX_W     = 4;
    localparam int TIME_W     = 32;
    localparam int VCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // Width used for count arithmetic, wide enough for any pool size up to 255.
    localparam int WIDE_W = 8;

    // Event kinds carried on s_tuser.
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEALING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } pva_state_t;

endpackage

### design/polyphonic_voice_allocator_top.sv
// Polyphonic voice allocator top level. Depends on pva_pkg and pva_start_mem.
// Start and finish beats give no result. A request that finds
// an idle voice gives its result in the cycle after the beat; a request that steals
// scans the start-time memory of the active voices one entry per cycle and gives its result
// when the scan ends, taking no new beat until then; a held result holds input.
// Reset is synchronous, active low: all voices idle, start times zero, config defaults.
module polyphonic_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = DEFAULT_MAX_VOICES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // voice_index[3:0], now_time[35:4], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // voice_found[0], granted_voice[4:1],
                                             // was_stolen[5], zero pad
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);
    localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_VOICES);

    pva_state_t              state_reg, state_next;
    logic                    stealing_reg;
    logic [VCOUNT_W-1:0]     vcount_reg;
    logic [MAX_VOICES-1:0]   busy_reg, busy_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [TIME_W-1:0]       oldest_reg, oldest_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        grant_reg, grant_next;
    logic                    stolen_reg, stolen_next;

    logic                    accept_in;
    logic [KIND_W-1:0]       in_kind;
    logic [VIDX_W-1:0]       in_vidx;
    logic [TIME_W-1:0]       in_time;
    logic [WIDE_W-1:0]       vidx_wide;
    logic                    vidx_ok;
    logic [IDX_W-1:0]        ev_idx;
    logic [WIDE_W-1:0]       count_wide;
    logic [WIDE_W-1:0]       n_wide;
    logic [CNT_W-1:0]        n_active;
    logic [MAX_VOICES-1:0]   active_mask;
    logic [MAX_VOICES-1:0]   idle_mask;
    logic                    idle_any;
    logic [IDX_W-1:0]        idle_idx;
    logic                    scan_last;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_raddr;
    logic [TIME_W-1:0]       mem_rdata;
    logic [WIDE_W-1:0]       grant_wide;

    // Unpack the input beat.
    assign in_kind   = s_tuser;
    assign in_vidx   = s_tdata[VIDX_W-1:0];
    assign in_time   = s_tdata[VIDX_W+TIME_W-1:VIDX_W];
    assign vidx_wide = WIDE_W'(in_vidx);
    assign vidx_ok   = (vidx_wide < MAX_WIDE);
    assign ev_idx    = vidx_wide[IDX_W-1:0];

    // Active voice count, saturated at the pool size.
    assign count_wide = WIDE_W'(vcount_reg);
    assign n_wide     = (count_wide > MAX_WIDE) ? MAX_WIDE : count_wide;
    assign n_active   = n_wide[CNT_W-1:0];

    for (genvar g = 0; g < MAX_VOICES; g++) begin : g_active
        assign active_mask[g] = (CNT_W'(g) < n_active);
    end

    // Lowest-index idle voice among the active ones.
    assign idle_mask = active_mask & ~busy_reg;
    assign idle_any  = |idle_mask;
    always_comb begin
        idle_idx = '0;
        for (int i = MAX_VOICES - 1; i >= 0; i--) begin
            if (idle_mask[i]) begin
                idle_idx = IDX_W'(i);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stealing_reg <= 1'b0;
            vcount_reg   <= VCOUNT_W'(16);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STEALING: stealing_reg <= cfg_wdata[0];
                CFG_COUNT:    vcount_reg   <= cfg_wdata[VCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Take a new beat only between items and once the output slot frees up.
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept_in = s_tvalid && s_tready;

    // Start-time memory: written by start events, read by the oldest-voice scan.
    assign mem_we    = accept_in && (in_kind == KIND_START) && vidx_ok;
    assign mem_raddr = (state_reg == ST_SCAN) ? (scan_idx_reg + 1'b1) : '0;

    pva_start_mem #(
        .DEPTH  (MAX_VOICES),
        .ADDR_W (IDX_W)
    ) u_start_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (ev_idx),
        .wr_data (in_time),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign scan_last = (WIDE_W'(scan_idx_reg) == (n_wide - 1'b1));

    // Controller: event handling, idle grant, and the oldest-voice scan.
    always_comb begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        scan_idx_next = scan_idx_reg;
        best_next     = best_reg;
        oldest_next   = oldest_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        found_next    = found_reg;
        grant_next    = grant_reg;
        stolen_next   = stolen_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (in_kind == KIND_FINISH && vidx_ok) begin
                        busy_next[ev_idx] = 1'b0;
                    end else if (in_kind == KIND_REQUEST) begin
                        if (idle_any) begin
                            busy_next[idle_idx] = 1'b1;
                            m_valid_next = 1'b1;
                            found_next   = 1'b1;
                            grant_next   = idle_idx;
                            stolen_next  = 1'b0;
                        end else if (stealing_reg && (n_active != '0)) begin
                            // Entry 0 is read on this edge; the scan starts with it.
                            state_next    = ST_SCAN;
                            scan_idx_next = '0;
                        end else begin
                            m_valid_next = 1'b1;
                            found_next   = 1'b0;
                            grant_next   = '0;
                            stolen_next  = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // Keep the first entry, then only strictly older ones.
                if (scan_idx_reg == '0 || mem_rdata < oldest_reg) begin
                    best_next   = scan_idx_reg;
                    oldest_next = mem_rdata;
                end
                if (scan_last) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    found_next   = 1'b1;
                    grant_next   = best_next;
                    stolen_next  = 1'b1;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Scan and result payload registers.
    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        best_reg     <= best_next;
        oldest_reg   <= oldest_next;
        found_reg    <= found_next;
        grant_reg    <= grant_next;
        stolen_reg   <= stolen_next;
    end

    // Pack the result beat.
    assign grant_wide = WIDE_W'(grant_reg);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {2'b00, stolen_reg, grant_wide[VIDX_W-1:0], found_reg};

    // The scan never overlaps a new input beat or a pending result.
    a_scan_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (!s_tready && !m_valid_reg))
        else $error("input accepted or result pending during scan");

    // A stolen grant is always a found grant.
    a_stolen_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && stolen_reg) |-> found_reg)
        else $error("stolen flag without a granted voice");

    // An idle grant leaves the granted voice busy.
    a_grant_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && found_reg && !stolen_reg) |-> busy_reg[grant_reg])
        else $error("granted voice not marked busy");

    // A scan that completes always delivers a result on the next cycle.
    a_scan_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && scan_last) |=> (m_valid_reg && stolen_reg))
        else $error("scan finished without a result");

endmodule

### design/pva_start_mem.sv
// Start-time memory for the voice allocator: one write and one registered read port.
// Entries never written since reset read as zero. Depends on pva_pkg.
module pva_start_mem
    import pva_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_VOICES,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic              rd_written_reg;

    // Storage array and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Written marks stand in for clearing the array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

### sim/pva_alloc_checker.sv
// Scoreboard for the polyphonic voice allocator: watches the input, result and register ports.
// It predicts every grant and compares it with the result beats.
// Depends on pva_pkg only.
module pva_alloc_checker
    import pva_pkg::*;
#(
    parameter int MAX_VOICES = DEFAULT_MAX_VOICES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // voice_index[3:0], now_time[35:4], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // voice_found[0], granted_voice[4:1],
                                             // was_stolen[5], zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_count,
    output int                    checked_count,
    output int                    stolen_count,
    output logic [VIDX_W-1:0]     last_grant
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              found;
        logic [VIDX_W-1:0] voice;
        logic              stolen;
    } grant_t;

    // Shadow copy of the voice pool and the two registers.
    logic              voice_busy [MAX_VOICES];
    logic [TIME_W-1:0] voice_start [MAX_VOICES];
    logic              steal_en;
    logic [VCOUNT_W-1:0] voice_count;
    grant_t            grant_queue [$];

    // Lowest idle voice first; otherwise the oldest start time when stealing is on.
    function automatic grant_t allocate_voice();
        grant_t            g;
        int                active;
        int                best;
        logic [TIME_W-1:0] oldest;
        g = '0;
        active = (voice_count > MAX_VOICES) ? MAX_VOICES : int'(voice_count);
        for (int i = 0; i < active; i++) begin
            if (!voice_busy[i]) begin
                voice_busy[i] = 1'b1;
                g.found = 1'b1;
                g.voice = VIDX_W'(i);
                return g;
            end
        end
        if (steal_en && active > 0) begin
            best = 0;
            oldest = voice_start[0];
            for (int i = 1; i < active; i++) begin
                if (voice_start[i] < oldest) begin
                    oldest = voice_start[i];
                    best = i;
                end
            end
            g.found = 1'b1;
            g.voice = VIDX_W'(best);
            g.stolen = 1'b1;
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] grant check: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        grant_t            got;
        grant_t            want;
        grant_t            g;
        logic [VIDX_W-1:0] vidx;
        vidx = s_tdata[VIDX_W-1:0];
        if (!aresetn) begin
            for (int i = 0; i < MAX_VOICES; i++) begin
                voice_busy[i] = 1'b0;
                voice_start[i] = '0;
            end
            steal_en = 1'b0;
            voice_count = VCOUNT_W'(16);
            last_grant = '0;
            grant_queue.delete();
        end else begin
            // Register writes; spare indexes are ignored.
            if (cfg_we) begin
                case (cfg_index)
                    CFG_STEALING: steal_en = cfg_wdata[0];
                    CFG_COUNT:    voice_count = cfg_wdata[VCOUNT_W-1:0];
                    default: ;
                endcase
            end

            // Result beat against the oldest outstanding grant.
            if (m_tvalid && m_tready) begin
                got.found = m_tdata[0];
                got.voice = m_tdata[4:1];
                got.stolen = m_tdata[5];
                if (grant_queue.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%02h with no request outstanding",
                                              m_tdata));
                end else begin
                    want = grant_queue.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("voice_found %0b, expected %0b",
                                                  got.found, want.found));
                    if (got.voice !== want.voice)
                        report_mismatch($sformatf("granted_voice %0d, expected %0d",
                                                  got.voice, want.voice));
                    if (got.stolen !== want.stolen)
                        report_mismatch($sformatf("was_stolen %0b, expected %0b",
                                                  got.stolen, want.stolen));
                    checked_count++;
                    if (want.stolen)
                        stolen_count++;
                end
            end

            // Input beat updates the pool; only requests produce a result.
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_REQUEST: begin
                        g = allocate_voice();
                        grant_queue.push_back(g);
                        last_grant = g.voice;
                    end
                    KIND_START: begin
                        if (vidx < MAX_VOICES)
                            voice_start[vidx] = s_tdata[VIDX_W +: TIME_W];
                    end
                    KIND_FINISH: begin
                        if (vidx < MAX_VOICES)
                            voice_busy[vidx] = 1'b0;
                    end
                    default: ;
                endcase
            end
        end
        pending_count = grant_queue.size();
    end

endmodule

### sim/polyphonic_voice_allocator_top_test.sv
// Stimulus and verdict for polyphonic_voice_allocator_top: directed note events, then random
// note-on/note-off traffic over many register settings with random idling on both streams.
// Depends on pva_pkg, the allocator RTL and pva_alloc_checker.
module polyphonic_voice_allocator_top_test
    import pva_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES   = 13;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_NS     = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int                fail_count;
    int                pending_count;
    int                checked_count;
    int                stolen_count;
    logic [VIDX_W-1:0] last_grant;

    int          burst_left;
    int          beats_sent;
    int unsigned sample_clock;

    polyphonic_voice_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pva_alloc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .stolen_count  (stolen_count),
        .last_grant    (last_grant)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Register settings per phase: {stealing, voice count}. Includes zero and saturating counts.
    function automatic logic [VCOUNT_W:0] phase_setting(input int p);
        case (p)
            0:  return {1'b1, 5'd16};
            1:  return {1'b1, 5'd1};
            2:  return {1'b0, 5'd1};
            3:  return {1'b1, 5'd0};
            4:  return {1'b0, 5'd0};
            5:  return {1'b1, 5'd5};
            6:  return {1'b0, 5'd7};
            7:  return {1'b1, 5'd31};
            8:  return {1'b0, 5'd20};
            9:  return {1'b1, 5'd12};
            10: return {1'b1, 5'd2};
            11: return {1'b0, 5'd16};
            default: return {1'b1, 5'd16};
        endcase
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 3);
            6, 7:             return $urandom_range(4, 10);
            default:          return $urandom_range(12, 40);
        endcase
    endfunction

    function automatic int pick_burst();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 8);
        return $urandom_range(20, 60);
    endfunction

    // One input beat. Bursts end in an idle gap; a beat may follow the latest predicted grant.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [VIDX_W-1:0] vidx,
                             input logic [TIME_W-1:0] stamp, input bit follow_grant);
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(negedge aclk);
            burst_left = pick_burst();
        end
        @(negedge aclk);
        if (follow_grant)
            vidx = last_grant;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(S_TDATA_W - TIME_W - VIDX_W){1'b0}}, stamp, vidx};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        beats_sent++;
    endtask

    // Hold the input side until every grant is back and the block has settled.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        burst_left = pick_burst();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly note-on (request, then start on the granted voice) and note-off traffic,
    // with stray events and the unused kind as noise.
    task automatic random_event(input int active);
        int                sel;
        logic [TIME_W-1:0] stamp;
        logic [VIDX_W-1:0] vidx;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            if ($urandom_range(0, 3) == 0) begin
                stamp = $urandom_range(0, 3);
            end else begin
                sample_clock += $urandom_range(1, 500);
                stamp = sample_clock;
            end
            send_beat(KIND_REQUEST, VIDX_W'($urandom), $urandom, 1'b0);
            send_beat(KIND_START, '0, stamp, 1'b1);
        end else if (sel < 70) begin
            if (active > 0 && $urandom_range(0, 4) != 0)
                vidx = VIDX_W'($urandom_range(0, active - 1));
            else
                vidx = VIDX_W'($urandom);
            send_beat(KIND_FINISH, vidx, $urandom, 1'b0);
        end else if (sel < 85) begin
            send_beat(KIND_REQUEST, VIDX_W'($urandom), $urandom, 1'b0);
        end else if (sel < 95) begin
            send_beat(KIND_START, VIDX_W'($urandom), $urandom, 1'b0);
        end else begin
            send_beat(KIND_UNUSED, VIDX_W'($urandom), $urandom, 1'b0);
        end
    endtask

    // Result side: stretches of always-ready, random, mostly-stalled and alternating.
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            for (int k = 0; k < span; k++) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= k[0];
                endcase
            end
        end
    end

    // Main stimulus.
    initial begin
        logic [VCOUNT_W:0] setting;
        int                active;
        int                target;
        int                first_beat;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_REQUEST;
        cfg_we = 1'b0;
        cfg_index = CFG_STEALING;
        cfg_wdata = '0;
        burst_left = 0;
        beats_sent = 0;
        sample_clock = 32'h100;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme start times, the unused kind, a full pool without stealing,
        // then freeing the lowest and highest voices.
        send_beat(KIND_START, 4'd0, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_START, 4'd15, 32'h0000_0000, 1'b0);
        send_beat(KIND_UNUSED, 4'd15, 32'hFFFF_FFFF, 1'b0);
        for (int i = 0; i < 16; i++)
            send_beat(KIND_REQUEST, VIDX_W'(15 - i), 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_REQUEST, 4'd0, 32'h0, 1'b0);
        send_beat(KIND_FINISH, 4'd15, 32'h0, 1'b0);
        send_beat(KIND_FINISH, 4'd0, 32'hFFFF_FFFF, 1'b0);
        send_beat(KIND_REQUEST, 4'd0, 32'h0, 1'b0);
        send_beat(KIND_REQUEST, 4'd0, 32'h0, 1'b0);
        send_beat(KIND_REQUEST, 4'd0, 32'h0, 1'b0);

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            setting = phase_setting(p);
            write_reg(CFG_STEALING, {4'($urandom_range(0, 15)), setting[VCOUNT_W]});
            write_reg(CFG_COUNT, setting[VCOUNT_W-1:0]);
            if (p % 3 == 1)
                write_reg((p % 2) ? CFG_SPARE_B : CFG_SPARE_A, CFG_DATA_W'($urandom));
            active = (setting[VCOUNT_W-1:0] > 16) ? 16 : int'(setting[VCOUNT_W-1:0]);
            target = (active == 0) ? 40 : 135;
            first_beat = beats_sent;
            while (beats_sent - first_beat < target)
                random_event(active);
        end

        drain_results();
        $display("Run covered %0d input beats under %0d register settings, directed and random.",
                 beats_sent, NUM_PHASES + 1);
        $display("%0d grants were checked, %0d of them taken from the oldest busy voice.",
                 checked_count, stolen_count);
        if (fail_count == 0) begin
            $display("polyphonic_voice_allocator_top verification clean");
        end else begin
            $display("polyphonic_voice_allocator_top verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(LIMIT_NS);
        $display("Timed out with %0d grants outstanding.", pending_count);
        $display("polyphonic_voice_allocator_top verification failed");
        $finish;
    end

endmodule

### sim.f
design/pva_pkg.sv
design/pva_start_mem.sv
design/polyphonic_voice_allocator_top.sv
sim/pva_alloc_checker.sv
sim/polyphonic_voice_allocator_top_test.sv
